>>> rtl/core/lncd_pkg.sv
`timescale 1ns / 1ps

package lncd_pkg;

  // Result kinds, as seen on the output tuser
  typedef enum logic [2:0] {
    ACT_ERROR         = 3'd0,
    ACT_CALIBRATE     = 3'd1,
    ACT_TARGET        = 3'd2,
    ACT_TONE          = 3'd3,
    ACT_PRESET_HI_SET = 3'd4,
    ACT_PRESET_LO_SET = 3'd5
  } action_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MIN_LIMIT     = 3'd0,
    REG_MAX_LIMIT     = 3'd1,
    REG_CODE_CAL      = 3'd2,
    REG_CODE_POSITION = 3'd3,
    REG_CODE_PRE_HI   = 3'd4,
    REG_CODE_PRE_LO   = 3'd5,
    REG_CODE_TONE     = 3'd6
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ErrW     = 3;
  localparam int unsigned NibW     = 4;
  localparam int unsigned CntW     = 5;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned InDataW  = 16;

  localparam logic [CntW-1:0] CntMax     = 5'd31;
  localparam logic [NibW-1:0] LenNone    = 4'd0;
  localparam logic [NibW-1:0] LenWord    = 4'd2;

  // Result queue: room for both results of one byte on top of two still waiting
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;
  localparam logic [FifoCntW-1:0] FifoTakeMax = 3'd2;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic [ErrW-1:0]  rx_errors;
  } in_beat_t;

  typedef struct packed {
    action_e           action;
    logic [ValueW-1:0] value;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } core_res_t;

endpackage

>>> rtl/core/length_nibble_command_deframer.sv
`timescale 1ns / 1ps
// Path: an accepted byte waits in the input register until the result queue has room, then
//   is decoded and queued; its results reach the master side after those queued before it.
// Throughput: one byte per cycle, back to back, while the output keeps up; a byte yields
//   0, 1 or 2 results, drained one per cycle from a four-slot queue. The held byte waits
//   while more than two results are queued, and the input stalls behind it.
// Reset: rst_ni is asynchronous, active low; clears frame state and presets, loads defaults.

module length_nibble_command_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Byte input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lncd_pkg::InDataW-1:0]  s_axis_tdata,   // [7:0] rx_byte, [10:8] rx_errors
  // Result output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lncd_pkg::ValueW-1:0]   m_axis_tdata,   // [15:0] value
  output logic [2:0]                    m_axis_tuser,   // [2:0] action
  output logic                          m_axis_tlast,   // last result of a byte
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [lncd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lncd_pkg::CfgDataW-1:0] cfg_data_i
);
  import lncd_pkg::*;

  logic      in_valid;
  logic      take;
  logic      space;
  in_beat_t  beat;
  core_res_t core_res;
  result_t   out_res;

  // Hold each byte in the input register until the result queue has room
  // for the worst case of two results; then decode it and advance.
  assign take = in_valid && space;

  lncd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .s_tdata_i (s_axis_tdata),
    .take_i    (take),
    .valid_o   (in_valid),
    .beat_o    (beat)
  );

  // Error tracking, header/payload counting and command decode
  lncd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .take_i    (take),
    .beat_i    (beat),
    .res_o     (core_res)
  );

  // Results leave one beat at a time; an error report goes out ahead of
  // the frame result caused by the same byte.
  lncd_res_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (core_res),
    .push_en_i (take),
    .space_o   (space),
    .m_tvalid_o(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_res_o   (out_res)
  );

  assign m_axis_tdata = out_res.value;
  assign m_axis_tuser = 3'(out_res.action);
  assign m_axis_tlast = out_res.last;

endmodule

>>> rtl/core/lncd_in_stage.sv
`timescale 1ns / 1ps

module lncd_in_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  output logic                      s_tready_o,
  input  logic [lncd_pkg::InDataW-1:0] s_tdata_i,
  input  logic                      take_i,
  output logic                      valid_o,
  output lncd_pkg::in_beat_t        beat_o
);
  import lncd_pkg::*;

  logic     valid_q, valid_d;
  in_beat_t beat_q;

  // Refill whenever the held beat is empty or being consumed this cycle
  assign s_tready_o = !valid_q || take_i;
  assign valid_d    = (s_tvalid_i && s_tready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      beat_q.rx_byte   <= s_tdata_i[ByteW-1:0];
      beat_q.rx_errors <= s_tdata_i[ByteW+ErrW-1:ByteW];
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

>>> rtl/core/lncd_core.sv
`timescale 1ns / 1ps

module lncd_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lncd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lncd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          take_i,
  input  lncd_pkg::in_beat_t            beat_i,
  output lncd_pkg::core_res_t           res_o
);
  import lncd_pkg::*;

  // Configuration
  logic [ValueW-1:0] min_limit_q, max_limit_q;
  logic [NibW-1:0]   code_cal_q, code_pos_q, code_phi_q, code_plo_q, code_tone_q;

  // Frame state
  logic [NibW-1:0]   exp_len_q, exp_len_d;
  logic [NibW-1:0]   cmd_q, cmd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ByteW-1:0]  pl_q, pl_d, ph_q, ph_d;
  logic [ErrW-1:0]   rep_err_q, rep_err_d;
  logic [ValueW-1:0] pre_hi_q, pre_hi_d, pre_lo_q, pre_lo_d;

  logic              hdr, done, err_hit, f_valid;
  logic [CntW-1:0]   cnt_base;
  logic [ValueW-1:0] word, f_value;
  action_e           f_action;
  result_t           err_res, frm_res;

  always_comb begin
    hdr       = (exp_len_q == LenNone);
    exp_len_d = hdr ? beat_i.rx_byte[7:4] : exp_len_q;
    cmd_d     = hdr ? beat_i.rx_byte[3:0] : cmd_q;
    cnt_base  = hdr ? '0 : cnt_q;
    pl_d      = (cnt_base == CntW'(1)) ? beat_i.rx_byte : pl_q;
    ph_d      = (cnt_base == CntW'(2)) ? beat_i.rx_byte : ph_q;
    cnt_d     = (cnt_base < CntMax) ? cnt_base + CntW'(1) : cnt_base;
    done      = ({1'b0, cnt_d} >= ({2'b00, exp_len_d} + 6'd1));
    word      = {ph_d, pl_d};

    err_hit   = (beat_i.rx_errors != '0) && (beat_i.rx_errors != rep_err_q);
    rep_err_d = err_hit ? beat_i.rx_errors : rep_err_q;

    f_valid   = 1'b0;
    f_action  = ACT_CALIBRATE;
    f_value   = '0;
    pre_hi_d  = pre_hi_q;
    pre_lo_d  = pre_lo_q;
    if (done) begin
      priority if (cmd_d == code_cal_q && exp_len_d == LenNone) begin
        f_valid  = 1'b1;
        f_action = ACT_CALIBRATE;
      end else if (cmd_d == code_pos_q && exp_len_d == LenWord) begin
        f_valid  = (word <= max_limit_q) && (word >= min_limit_q);
        f_action = ACT_TARGET;
        f_value  = word;
      end else if (cmd_d == code_phi_q && exp_len_d == LenNone) begin
        f_valid  = 1'b1;
        f_action = ACT_TARGET;
        f_value  = pre_hi_q;
      end else if (cmd_d == code_phi_q && exp_len_d == LenWord) begin
        f_valid  = 1'b1;
        f_action = ACT_PRESET_HI_SET;
        f_value  = word;
        pre_hi_d = word;
      end else if (cmd_d == code_plo_q && exp_len_d == LenNone) begin
        f_valid  = 1'b1;
        f_action = ACT_TARGET;
        f_value  = pre_lo_q;
      end else if (cmd_d == code_plo_q && exp_len_d == LenWord) begin
        f_valid  = 1'b1;
        f_action = ACT_PRESET_LO_SET;
        f_value  = word;
        pre_lo_d = word;
      end else if (cmd_d == code_tone_q && exp_len_d == LenWord) begin
        f_valid  = 1'b1;
        f_action = ACT_TONE;
        f_value  = word;
      end else begin
        f_valid  = 1'b0;
      end
    end

    err_res.action = ACT_ERROR;
    err_res.value  = ValueW'(beat_i.rx_errors);
    err_res.last   = !f_valid;
    frm_res.action = f_action;
    frm_res.value  = f_value;
    frm_res.last   = 1'b1;

    res_o.num  = 2'({1'b0, err_hit} + {1'b0, f_valid});
    res_o.res0 = err_hit ? err_res : frm_res;
    res_o.res1 = frm_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_limit_q <= '0;
      max_limit_q <= '1;
      code_cal_q  <= 4'd0;
      code_pos_q  <= 4'd1;
      code_phi_q  <= 4'd2;
      code_plo_q  <= 4'd3;
      code_tone_q <= 4'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_LIMIT:     min_limit_q <= cfg_data_i;
        REG_MAX_LIMIT:     max_limit_q <= cfg_data_i;
        REG_CODE_CAL:      code_cal_q  <= cfg_data_i[NibW-1:0];
        REG_CODE_POSITION: code_pos_q  <= cfg_data_i[NibW-1:0];
        REG_CODE_PRE_HI:   code_phi_q  <= cfg_data_i[NibW-1:0];
        REG_CODE_PRE_LO:   code_plo_q  <= cfg_data_i[NibW-1:0];
        REG_CODE_TONE:     code_tone_q <= cfg_data_i[NibW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= '0;
      cmd_q     <= '0;
      cnt_q     <= '0;
      pl_q      <= '0;
      ph_q      <= '0;
      rep_err_q <= '0;
      pre_hi_q  <= '0;
      pre_lo_q  <= '0;
    end else if (take_i) begin
      // a completed frame drops back to awaiting a header
      exp_len_q <= done ? LenNone : exp_len_d;
      cmd_q     <= cmd_d;
      cnt_q     <= cnt_d;
      pl_q      <= pl_d;
      ph_q      <= ph_d;
      rep_err_q <= rep_err_d;
      pre_hi_q  <= pre_hi_d;
      pre_lo_q  <= pre_lo_d;
    end
  end

  a_err_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.num != 2'd0 && res_o.res0.action == ACT_ERROR) |-> (res_o.res0.value != '0))
    else $error("error report with empty flags");

  a_err_repeat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && res_o.num != 2'd0 && res_o.res0.action == ACT_ERROR)
      |=> (rep_err_q == $past(beat_i.rx_errors)))
    else $error("reported error combination not recorded");

endmodule

>>> rtl/core/lncd_res_fifo.sv
`timescale 1ns / 1ps

module lncd_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lncd_pkg::core_res_t push_i,
  input  logic                push_en_i,
  output logic                space_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output lncd_pkg::result_t   m_res_o
);
  import lncd_pkg::*;

  result_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [1:0]          push_num;
  logic                pop;

  assign push_num   = push_en_i ? push_i.num : 2'd0;
  assign pop        = m_tvalid_o && m_tready_i;
  assign wr_ptr_nx  = wr_ptr_q + FifoPtrW'(1);
  assign space_o    = (cnt_q <= FifoTakeMax);
  assign m_tvalid_o = (cnt_q != '0);
  assign m_res_o    = mem_q[rd_ptr_q];
  assign cnt_d      = cnt_q + FifoCntW'(push_num) - FifoCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoPtrW'(push_num);
      rd_ptr_q <= rd_ptr_q + FifoPtrW'(pop);
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_num == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.res1;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("result queue overflow");

  a_push_space : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_num != 2'd0) |-> space_o)
    else $error("push without room for two results");

  a_cnt_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_num == 2'd2 && !pop) |=> (cnt_q == $past(cnt_q) + FifoCntW'(2)))
    else $error("queue count lost a double push");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lncd_pkg::*;

  // Write to the spare index past the register list; the block must ignore it
  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;
  // Stop when this many cycles pass with no beat on either side and no register write
  localparam int StallLimit = 2000;
  // Cycles to hold after the last expected result before touching registers
  localparam int DrainCycles = 4;
  localparam int RandomPhases = 9;
  localparam int BeatsPerPhase = 220;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // [7:0] rx_byte, [10:8] rx_errors
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [ValueW-1:0]   m_axis_tdata;          // [15:0] value
  logic [2:0]          m_axis_tuser;          // [2:0] action
  logic                m_axis_tlast;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  length_nibble_command_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the register file, updated as each write is issued
  logic [15:0] lim_min = 16'd0;
  logic [15:0] lim_max = 16'hFFFF;
  logic [3:0]  op_cal  = 4'd0;
  logic [3:0]  op_pos  = 4'd1;
  logic [3:0]  op_hi   = 4'd2;
  logic [3:0]  op_lo   = 4'd3;
  logic [3:0]  op_tone = 4'd4;

  // Shadow copy of the frame state and the stored presets
  logic [3:0]  frame_len      = '0;
  logic [3:0]  frame_cmd      = '0;
  logic [4:0]  beat_cnt       = '0;
  logic [7:0]  word_lo        = '0;
  logic [7:0]  word_hi        = '0;
  logic [2:0]  flags_reported = '0;
  logic [15:0] preset_hi      = '0;
  logic [15:0] preset_lo      = '0;

  logic [InDataW-1:0] bytes_to_send[$];   // serial bytes waiting for the driver
  result_t            results_due[$];     // decoded results not yet seen on the output

  // 0: sender idles 29%, receiver 73%; 1: the reverse; 2: no idling
  int idle_mode = 0;
  int bytes_queued = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  int kind_seen[6] = '{default: 0};

  function automatic bit sender_idles();
    case (idle_mode)
      0: return $urandom_range(0, 99) < 29;
      1: return $urandom_range(0, 99) < 73;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_idles();
    case (idle_mode)
      0: return $urandom_range(0, 99) < 73;
      1: return $urandom_range(0, 99) < 29;
      default: return 1'b0;
    endcase
  endfunction

  function automatic result_t make_result(input action_e act, input logic [15:0] val);
    make_result = '{action: act, value: val, last: 1'b0};
  endfunction

  // Advance the shadow deframer by one received byte and queue what it yields
  task automatic decode_byte(input logic [7:0] rx, input logic [2:0] flags);
    result_t     made[2];
    int          n;
    logic [15:0] word;
    n = 0;
    // A fresh nonzero error combination is reported ahead of any frame result
    if (flags != 3'd0 && flags != flags_reported) begin
      flags_reported = flags;
      made[n] = make_result(ACT_ERROR, {13'd0, flags});
      n++;
    end
    // Latch the header while no frame is open
    if (frame_len == LenNone) begin
      frame_len = rx[7:4];
      frame_cmd = rx[3:0];
      beat_cnt  = '0;
    end
    // Keep the first two payload bytes only; count the rest
    if (beat_cnt == 5'd1) word_lo = rx;
    else if (beat_cnt == 5'd2) word_hi = rx;
    if (beat_cnt < CntMax) beat_cnt++;
    if (int'(beat_cnt) >= int'(frame_len) + 1) begin
      word = {word_hi, word_lo};
      // First matching decode wins when command codes coincide
      if (frame_cmd == op_cal && frame_len == LenNone) begin
        made[n] = make_result(ACT_CALIBRATE, 16'd0);
        n++;
      end else if (frame_cmd == op_pos && frame_len == LenWord) begin
        if (word >= lim_min && word <= lim_max) begin
          made[n] = make_result(ACT_TARGET, word);
          n++;
        end
      end else if (frame_cmd == op_hi && frame_len == LenNone) begin
        made[n] = make_result(ACT_TARGET, preset_hi);
        n++;
      end else if (frame_cmd == op_hi && frame_len == LenWord) begin
        preset_hi = word;
        made[n] = make_result(ACT_PRESET_HI_SET, word);
        n++;
      end else if (frame_cmd == op_lo && frame_len == LenNone) begin
        made[n] = make_result(ACT_TARGET, preset_lo);
        n++;
      end else if (frame_cmd == op_lo && frame_len == LenWord) begin
        preset_lo = word;
        made[n] = make_result(ACT_PRESET_LO_SET, word);
        n++;
      end else if (frame_cmd == op_tone && frame_len == LenWord) begin
        made[n] = make_result(ACT_TONE, word);
        n++;
      end
      frame_len = LenNone;
    end
    if (n > 0) made[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) results_due.push_back(made[i]);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endtask

  // Driver: present queued bytes, hold a beat until it is taken, idle at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      // Predict from the beat that the block takes at this edge
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata[7:0], s_axis_tdata[10:8]);
        bytes_sent++;
      end
      // Load the next beat only when the slot is free; one assignment per edge
      if (!s_axis_tvalid || s_axis_tready) begin
        if (bytes_to_send.size() != 0 && !sender_idles()) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= bytes_to_send.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the result side at random and check every beat taken
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !receiver_idles();
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (m_axis_tuser <= ACT_PRESET_LO_SET) kind_seen[m_axis_tuser]++;
        if (results_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: action %0d value %h last %b",
                                  m_axis_tuser, m_axis_tdata, m_axis_tlast));
        end else begin
          want = results_due.pop_front();
          if (m_axis_tuser !== want.action || m_axis_tdata !== want.value ||
              m_axis_tlast !== want.last) begin
            flag_mismatch($sformatf({"result %0d: expected action %0d value %h last %b,",
                                     " got action %0d value %h last %b"},
                                    results_seen, want.action, want.value, want.last,
                                    m_axis_tuser, m_axis_tdata, m_axis_tlast));
          end
        end
      end
    end
  end

  // Watchdog: give up when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_beat(input logic [7:0] rx, input logic [2:0] flags);
    bytes_to_send.push_back({5'd0, flags, rx});
    bytes_queued++;
  endtask

  // Mostly clean bytes; now and then a random error combination
  function automatic logic [2:0] pick_flags();
    if ($urandom_range(0, 99) < 85) return 3'd0;
    return 3'($urandom_range(1, 7));
  endfunction

  // Position targets cluster on and just past the limits
  function automatic logic [15:0] pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (lim_min > lim_max || r >= 90) return 16'($urandom);
    if (r < 40) return 16'($urandom_range(lim_max, lim_min));
    if (r < 55) return lim_min;
    if (r < 70) return lim_max;
    if (r < 80) return lim_min - 16'd1;
    return lim_max + 16'd1;
  endfunction

  // Header, then len payload bytes; the first two carry the word little-endian
  task automatic queue_frame(input logic [3:0] cmd, input logic [3:0] len,
                             input logic [15:0] word);
    queue_beat({len, cmd}, pick_flags());
    for (int i = 1; i <= len; i++)
      queue_beat(i == 1 ? word[7:0] : i == 2 ? word[15:8] : 8'($urandom), pick_flags());
  endtask

  // Hold until the driver is empty and every expected result has arrived, then drain
  task automatic settle();
    while (bytes_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_MIN_LIMIT:     lim_min = data;
      REG_MAX_LIMIT:     lim_max = data;
      REG_CODE_CAL:      op_cal  = data[3:0];
      REG_CODE_POSITION: op_pos  = data[3:0];
      REG_CODE_PRE_HI:   op_hi   = data[3:0];
      REG_CODE_PRE_LO:   op_lo   = data[3:0];
      REG_CODE_TONE:     op_tone = data[3:0];
      default: ;
    endcase
  endtask

  // Load one register setting per phase; the first few hit the extremes
  task automatic apply_setting(input int which);
    logic [15:0] lo, hi, tmp;
    logic [3:0]  c0, c1, c2, c3, c4;
    case (which)
      0: begin
        lo = 16'h0100; hi = 16'hFEFF;
        {c0, c1, c2, c3, c4} = {4'd8, 4'd9, 4'd10, 4'd11, 4'd12};
      end
      1: begin
        // single accepted target; codes at the top of the nibble
        lo = 16'h8000; hi = 16'h8000;
        {c0, c1, c2, c3, c4} = {4'd15, 4'd14, 4'd13, 4'd12, 4'd11};
      end
      2: begin
        // crossed limits: no target is accepted
        lo = 16'hF000; hi = 16'h0FFF;
        {c0, c1, c2, c3, c4} = {4'd0, 4'd1, 4'd2, 4'd3, 4'd4};
      end
      3: begin
        // every code the same: decode priority decides
        lo = 16'hFFFF; hi = 16'hFFFF;
        {c0, c1, c2, c3, c4} = {4'd7, 4'd7, 4'd7, 4'd7, 4'd7};
      end
      4: begin
        lo = 16'h0000; hi = 16'h0000;
        {c0, c1, c2, c3, c4} = {4'd5, 4'd5, 4'd6, 4'd6, 4'd5};
      end
      5: begin
        lo = 16'h0000; hi = 16'hFFFF;
        {c0, c1, c2, c3, c4} = {4'd0, 4'd1, 4'd2, 4'd3, 4'd4};
      end
      default: begin
        lo = 16'($urandom);
        hi = 16'($urandom);
        if (lo > hi) begin
          tmp = lo; lo = hi; hi = tmp;
        end
        c0 = 4'($urandom); c1 = 4'($urandom); c2 = 4'($urandom);
        c3 = 4'($urandom); c4 = 4'($urandom);
      end
    endcase
    write_reg(REG_MIN_LIMIT, lo);
    write_reg(REG_MAX_LIMIT, hi);
    write_reg(REG_CODE_CAL, {12'd0, c0});
    write_reg(REG_CODE_POSITION, {12'd0, c1});
    write_reg(REG_CODE_PRE_HI, {12'd0, c2});
    write_reg(REG_CODE_PRE_LO, {12'd0, c3});
    write_reg(REG_CODE_TONE, {12'd0, c4});
    if (which == 2) write_reg(RegSpare, 16'hFFFF);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int goal;
    int pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset codes: calibrate 0, position 1,
    // high preset 2, low preset 3, tone 4; limits span the whole range
    queue_beat(8'h00, 3'b111);                 // all error flags, then calibrate
    queue_beat(8'h00, 3'b111);                 // same flags again: no report
    queue_beat(8'h21, 3'b000);                 // position 0x0000
    queue_beat(8'h00, 3'b001);                 // parity error mid-frame
    queue_beat(8'h00, 3'b000);
    queue_beat(8'h21, 3'b000);                 // position 0xFFFF
    queue_beat(8'hFF, 3'b000);
    queue_beat(8'hFF, 3'b000);
    queue_beat(8'h03, 3'b000);                 // recall low preset before any store
    queue_beat(8'h22, 3'b000);                 // store high preset 0x1234
    queue_beat(8'h34, 3'b000);
    queue_beat(8'h12, 3'b010);                 // overflow flag on the completing byte
    queue_beat(8'h02, 3'b000);                 // recall high preset
    queue_beat(8'h23, 3'b000);                 // store low preset 0xABCD
    queue_beat(8'hCD, 3'b000);
    queue_beat(8'hAB, 3'b000);
    queue_beat(8'h03, 3'b000);                 // recall low preset
    queue_beat(8'h24, 3'b100);                 // tone 0x0280 with framing error
    queue_beat(8'h80, 3'b000);
    queue_beat(8'h02, 3'b000);
    queue_beat(8'h05, 3'b000);                 // unknown command: consumed silently
    queue_beat(8'h14, 3'b000);                 // tone with one byte: no result
    queue_beat(8'h55, 3'b000);
    queue_beat(8'h31, 3'b000);                 // position with three bytes: no result
    queue_beat(8'h11, 3'b000);
    queue_beat(8'h22, 3'b000);
    queue_beat(8'h33, 3'b000);
    // Sender pauses here until every expected result has come
    settle();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      idle_mode = ph / 3;
      apply_setting(ph);
      goal = bytes_queued + BeatsPerPhase;
      while (bytes_queued < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          // well-formed frame for one of the configured commands
          case ($urandom_range(0, 6))
            0: queue_frame(op_cal, LenNone, 16'd0);
            1: queue_frame(op_pos, LenWord, pick_target());
            2: queue_frame(op_hi, LenNone, 16'd0);
            3: queue_frame(op_hi, LenWord, 16'($urandom));
            4: queue_frame(op_lo, LenNone, 16'd0);
            5: queue_frame(op_lo, LenWord, 16'($urandom));
            default: queue_frame(op_tone, LenWord, 16'($urandom));
          endcase
        end else if (pick < 92) begin
          // arbitrary command and length, long payloads now and then
          queue_frame(4'($urandom),
                      ($urandom_range(0, 2) != 0) ? 4'($urandom_range(0, 4)) : 4'($urandom),
                      16'($urandom));
        end else if (pick < 96) begin
          // lone random byte
          queue_beat(8'($urandom), pick_flags());
        end else begin
          // header with a payload that never comes; the next frame fills it
          queue_beat({4'($urandom_range(1, 15)), 4'($urandom)}, pick_flags());
        end
      end
      settle();
    end

    $display("covered %0d bytes under %0d register settings plus reset values, %0d results",
             bytes_sent, settings_used, results_seen);
    $display("results: %0d error, %0d calibrate, %0d target, %0d tone, %0d/%0d preset stores",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5]);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
